// File: hdl/rv32x_pkg.sv
// ----------------------------------------------------------------------------
// rv32x_pkg: shared types, encodings and decode for the RV32I subset unit
// Opcodes, function codes, result beat layout and the execute function that
// turns one instruction and its operands into a result record.
// ----------------------------------------------------------------------------
package rv32x_pkg;

  localparam int DMEM_WORDS_DEF = 1024;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;

  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_JALR = 3'd0;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // result beat layout, lowest bit first
  localparam int OUT_KNOWN  = 0;
  localparam int OUT_HALTED = 1;
  localparam int OUT_NPC    = 2;
  localparam int OUT_RD     = 34;
  localparam int OUT_WVAL   = 39;
  localparam int OUT_ST     = 71;
  localparam int OUT_SADDR  = 72;
  localparam int OUT_SDATA  = 104;
  localparam int OUT_W      = 136;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic        known;
    logic        halted;
    logic [31:0] npc;
    logic        wr_en;
    logic [4:0]  rd;
    logic [31:0] wval;
    logic        is_load;
    logic        st;
    logic [31:0] saddr;
    logic [31:0] sdata;
  } res_t;

  typedef struct packed {
    res_t        res;
    logic [31:0] ea;
  } ex_t;

  function automatic ex_t execute(input logic [31:0] w, input logic [31:0] a,
                                  input logic [31:0] b, input logic [31:0] pc,
                                  input logic halt);
    ex_t         ex;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] snpc;
    logic        wr;
    logic [31:0] wval;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    snpc  = pc + 32'd4;
    wr    = 1'b0;
    wval  = '0;
    ex    = '0;
    ex.res.halted = halt;
    ex.res.npc    = pc;
    if (!halt) begin
      ex.res.known = 1'b1;
      ex.res.npc   = snpc;
      if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_ADD) begin
        wr = 1'b1; wval = a + b;
      end else if (opc == OPC_OP && f7 == F7_ALT && f3 == F3_ADD) begin
        wr = 1'b1; wval = a - b;
      end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_AND) begin
        wr = 1'b1; wval = a & b;
      end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_OR) begin
        wr = 1'b1; wval = a | b;
      end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_XOR) begin
        wr = 1'b1; wval = a ^ b;
      end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_SLL) begin
        wr = 1'b1; wval = a << b[4:0];
      end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_SR) begin
        wr = 1'b1; wval = a >> b[4:0];
      end else if (opc == OPC_OP && f7 == F7_ALT && f3 == F3_SR) begin
        wr = 1'b1; wval = $unsigned($signed(a) >>> b[4:0]);
      end else if (opc == OPC_OPIMM && f3 == F3_OR) begin
        wr = 1'b1; wval = a | imm_i;
      end else if (opc == OPC_OPIMM && f3 == F3_ADD) begin
        wr = 1'b1; wval = a + imm_i;
      end else if (opc == OPC_LOAD && f3 == F3_WORD) begin
        wr = 1'b1; ex.res.is_load = 1'b1; ex.ea = a + imm_i;
      end else if (opc == OPC_JALR && f3 == F3_JALR) begin
        ex.res.npc = (imm_i + a) & ~32'd1;
        wr = 1'b1; wval = snpc;
      end else if (w == WORD_EBREAK) begin
        ex.res.halted = 1'b1;
      end else if (opc == OPC_STORE && f3 == F3_WORD) begin
        ex.res.st    = 1'b1;
        ex.res.saddr = a + imm_s;
        ex.res.sdata = b;
        ex.ea        = a + imm_s;
      end else if (opc == OPC_BRANCH && f3 == F3_BEQ) begin
        ex.res.npc = (a == b) ? pc + imm_b : snpc;
      end else if (opc == OPC_BRANCH && f3 == F3_BNE) begin
        ex.res.npc = (a != b) ? pc + imm_b : snpc;
      end else if (opc == OPC_JAL) begin
        ex.res.npc = pc + imm_j;
        wr = 1'b1; wval = snpc;
      end else begin
        ex.res.known = 1'b0;
        ex.res.npc   = pc;
      end
      if (wr && w[11:7] != 5'd0) begin
        ex.res.wr_en = 1'b1;
        ex.res.rd    = w[11:7];
        ex.res.wval  = wval;
      end else begin
        ex.res.is_load = 1'b0;
      end
    end
    return ex;
  endfunction

endpackage

// File: hdl/rv32x_rf.sv
// ----------------------------------------------------------------------------
// rv32x_rf: 32 x 32 register file
// Synchronous memory with two registered read ports, one write port and a
// valid bit per entry so that unwritten registers, and x0, read as zero.
// ----------------------------------------------------------------------------
module rv32x_rf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [4:0]           rd_idx_a,
  input  logic [4:0]           rd_idx_b,
  output logic [31:0]          rd_data_a,
  output logic [31:0]          rd_data_b,
  input  rv32x_pkg::rf_wr_t    wr
);

  logic [31:0] mem [32];
  logic [31:0] valid;
  logic [31:0] a_data;
  logic [31:0] b_data;
  logic        a_valid;
  logic        b_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    a_data  <= mem[rd_idx_a];
    b_data  <= mem[rd_idx_b];
    a_valid <= valid[rd_idx_a];
    b_valid <= valid[rd_idx_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  assign rd_data_a = a_valid ? a_data : '0;
  assign rd_data_b = b_valid ? b_data : '0;

endmodule

// File: hdl/rv32x_dmem.sv
// ----------------------------------------------------------------------------
// rv32x_dmem: word data memory
// Single-port synchronous memory with a registered read. After reset it
// sweeps every word to zero, one word per cycle, and reports busy meanwhile.
// ----------------------------------------------------------------------------
module rv32x_dmem #(
  parameter int DMEM_WORDS = rv32x_pkg::DMEM_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          busy,
  input  logic                          en,
  input  logic                          we,
  input  logic [$clog2(DMEM_WORDS)-1:0] idx,
  input  logic [31:0]                   wdata,
  output logic [31:0]                   rdata
);

  localparam int AW = $clog2(DMEM_WORDS);
  localparam logic [AW-1:0] LAST = AW'(DMEM_WORDS - 1);

  logic [31:0]   mem [DMEM_WORDS];
  logic [AW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= '0;
    end else if (en && we) begin
      mem[idx] <= wdata;
    end
    if (en && !we) begin
      rdata <= mem[idx];
    end
  end

endmodule

// File: hdl/rv32i_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32i_subset_execute_unit: execute unit for an RV32I subset
// Decodes and runs one instruction per beat against its own register file,
// program counter, data memory and halt flag; one result beat per input.
// ----------------------------------------------------------------------------
// Input channel s_axis carries one 32-bit instruction per beat. Output
// channel m_axis returns exactly one result beat per instruction, in order.
// Pipeline: execute, two stages that reduce the word address modulo
// DMEM_WORDS (reciprocal multiply, then multiply-subtract), memory access,
// output register. Every beat passes through each stage in order. The unit
// takes one beat per cycle when no load hazard, stall or sweep holds it.
// An instruction whose rs1 or rs2 field names the destination of a load
// still in one of the three stages ahead of it waits until that load
// reaches the output register; every other dependence
// is forwarded. The load-to-output path is the single data memory port.
// Reset empties the pipeline, zeroes pc, registers and halt flag, and then
// sweeps the data memory to zero with s_axis_tready held low meanwhile.
// When m_axis_tready is low the stages ahead of the output register
// keep filling, and s_axis_tready drops once all of them are full.
// ----------------------------------------------------------------------------
module rv32i_subset_execute_unit #(
  parameter int DMEM_WORDS = rv32x_pkg::DMEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // instruction_word
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // known_instruction, halted, next_pc, write_reg_index, write_reg_value,
  // store_valid, store_address, store_data
  output logic [rv32x_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int AW = $clog2(DMEM_WORDS);
  localparam int XW = 30;
  localparam int SH = XW + AW;
  localparam int PW = 2 * XW + 2;
  localparam logic [XW+1:0] RECIP =
    (XW+2)'(((64'd1 << SH) + 64'(DMEM_WORDS) - 64'd1) / 64'(DMEM_WORDS));
  localparam logic [AW:0] DEPTH = (AW+1)'(DMEM_WORDS);

  logic                e_v, m1_v, m2_v, m3_v, w_v;
  logic [31:0]         e_instr;
  rv32x_pkg::res_t     m1_r, m2_r, m3_r, w_r;
  logic [XW-1:0]       m1_x, m2_x;
  logic [PW-1:0]       m2_prod;
  logic [AW-1:0]       m3_idx;
  logic [31:0]         pc;
  logic                halt;
  rv32x_pkg::rf_wr_t   rf_wr, lw;
  rv32x_pkg::ex_t      ex;
  logic [4:0]          ra, rb, rf_ra, rf_rb;
  logic [31:0]         rf_a, rf_b, op_a, op_b, ld_data, w_val;
  logic [XW-1:0]       q2, qd2, r2;
  logic                dmem_busy;
  logic                en_w, en_3, en_2, en_1, e_go, en_e, accept, hazard;

  assign ra = e_instr[19:15];
  assign rb = e_instr[24:20];

  assign en_w   = !w_v || m_axis_tready;
  assign en_3   = !m3_v || en_w;
  assign en_2   = !m2_v || en_3;
  assign en_1   = !m1_v || en_2;
  assign e_go   = e_v && !hazard && en_1;
  assign en_e   = !e_v || e_go;
  assign s_axis_tready = en_e && !dmem_busy;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign rf_ra = accept ? s_axis_tdata[19:15] : ra;
  assign rf_rb = accept ? s_axis_tdata[24:20] : rb;

  rv32x_rf u_rf (
    .clk       (clk),
    .rst       (rst),
    .rd_idx_a  (rf_ra),
    .rd_idx_b  (rf_rb),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr        (rf_wr)
  );

  rv32x_dmem #(.DMEM_WORDS(DMEM_WORDS)) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .busy  (dmem_busy),
    .en    (m3_v && en_w && (m3_r.is_load || m3_r.st)),
    .we    (m3_r.st),
    .idx   (m3_idx),
    .wdata (m3_r.sdata),
    .rdata (ld_data)
  );

  assign w_val = w_r.is_load ? ld_data : w_r.wval;

  always_comb begin
    rf_wr.en   = w_v && m_axis_tready && w_r.wr_en;
    rf_wr.idx  = w_r.rd;
    rf_wr.data = w_val;
  end

  always_comb begin
    hazard = (m1_v && m1_r.is_load && (m1_r.rd == ra || m1_r.rd == rb)) ||
             (m2_v && m2_r.is_load && (m2_r.rd == ra || m2_r.rd == rb)) ||
             (m3_v && m3_r.is_load && (m3_r.rd == ra || m3_r.rd == rb));
  end

  // youngest matching producer wins
  always_comb begin
    op_a = rf_a;
    op_b = rf_b;
    if (lw.en && lw.idx == ra) op_a = lw.data;
    if (lw.en && lw.idx == rb) op_b = lw.data;
    if (w_v && w_r.wr_en && w_r.rd == ra) op_a = w_val;
    if (w_v && w_r.wr_en && w_r.rd == rb) op_b = w_val;
    if (m3_v && m3_r.wr_en && m3_r.rd == ra) op_a = m3_r.wval;
    if (m3_v && m3_r.wr_en && m3_r.rd == rb) op_b = m3_r.wval;
    if (m2_v && m2_r.wr_en && m2_r.rd == ra) op_a = m2_r.wval;
    if (m2_v && m2_r.wr_en && m2_r.rd == rb) op_b = m2_r.wval;
    if (m1_v && m1_r.wr_en && m1_r.rd == ra) op_a = m1_r.wval;
    if (m1_v && m1_r.wr_en && m1_r.rd == rb) op_b = m1_r.wval;
  end

  assign ex = rv32x_pkg::execute(e_instr, op_a, op_b, pc, halt);

  assign q2  = XW'(m2_prod >> SH);
  assign qd2 = XW'(q2 * DEPTH);
  assign r2  = m2_x - qd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v    <= 1'b0;
      m1_v   <= 1'b0;
      m2_v   <= 1'b0;
      m3_v   <= 1'b0;
      w_v    <= 1'b0;
      pc     <= '0;
      halt   <= 1'b0;
      lw     <= '0;
    end else begin
      e_v  <= en_e ? accept : e_v;
      m1_v <= en_1 ? e_go : m1_v;
      m2_v <= en_2 ? m1_v : m2_v;
      m3_v <= en_3 ? m2_v : m3_v;
      w_v  <= en_w ? m3_v : w_v;
      lw   <= rf_wr;
      if (e_go) begin
        pc   <= ex.res.npc;
        halt <= ex.res.halted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_instr <= s_axis_tdata;
    end
    if (en_1) begin
      m1_r <= ex.res;
      m1_x <= ex.ea[31:2];
    end
    if (en_2) begin
      m2_r    <= m1_r;
      m2_x    <= m1_x;
      m2_prod <= PW'(m1_x) * PW'(RECIP);
    end
    if (en_3) begin
      m3_r   <= m2_r;
      m3_idx <= r2[AW-1:0];
    end
    if (en_w) begin
      w_r <= m3_r;
    end
  end

  assign m_axis_tvalid = w_v;
  assign m_axis_tdata  = {w_r.sdata, w_r.saddr, w_r.st, w_val, w_r.rd, w_r.npc,
                          w_r.halted, w_r.known};

endmodule

// File: hdl/rv32x_chk.sv
// ----------------------------------------------------------------------------
// rv32x_chk: port checker for the RV32I subset execute unit
// Watches the stream ports for reset behavior, output hold under stall,
// sticky halt and the encoding of result beats.
// ----------------------------------------------------------------------------
module rv32x_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [rv32x_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic seen_halt;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[rv32x_pkg::OUT_HALTED]) begin
      seen_halt <= 1'b1;
    end
  end

  a_reset_sweep: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready during memory sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && seen_halt |->
      m_axis_tdata[rv32x_pkg::OUT_HALTED] && !m_axis_tdata[rv32x_pkg::OUT_KNOWN])
    else $error("beat after halt not reported as halted and ignored");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[rv32x_pkg::OUT_RD +: 5] == 5'd0 |->
      m_axis_tdata[rv32x_pkg::OUT_WVAL +: 32] == 32'd0)
    else $error("write value without destination");

  a_store_no_write: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[rv32x_pkg::OUT_ST] |->
      m_axis_tdata[rv32x_pkg::OUT_RD +: 5] == 5'd0)
    else $error("store beat reports a register write");

endmodule

bind rv32i_subset_execute_unit rv32x_chk u_chk (.*);
